>>> sv/kpd_pkg.sv
package kpd_pkg;

   localparam int TICK_BITS      = 32;
   localparam int KEY_BITS       = 5;
   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [KEY_BITS-1:0] NO_KEY = 5'd16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_LONG_PRESS = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REPEAT     = 8'd1;

   localparam logic [CSR_DATA_BITS-1:0] LONG_PRESS_RESET = 16'd1000;
   localparam logic [CSR_DATA_BITS-1:0] REPEAT_RESET     = 16'd300;

   typedef enum logic [1:0] {
      PHASE_IDLE    = 2'd0,
      PHASE_TRIG    = 2'd1,
      PHASE_PRESSED = 2'd2,
      PHASE_LONG    = 2'd3
   } phase_type;

   typedef struct packed {
      logic [7:0]           scan_code;
      logic [TICK_BITS-1:0] tick_now;
   } req_item_type;

   typedef struct packed {
      logic       key_valid;
      logic [3:0] key_index;
   } rsp_item_type;

   localparam logic [7:0] KEY_CODES [16] = '{
      8'h77, 8'hb7, 8'hd7, 8'he7, 8'h7b, 8'hbb, 8'hdb, 8'heb,
      8'h7d, 8'hbd, 8'hdd, 8'hed, 8'h7e, 8'hbe, 8'hde, 8'hee
   };

   function automatic logic [KEY_BITS-1:0] decode_scan(input logic [7:0] code);
      logic [KEY_BITS-1:0] key;
      key = NO_KEY;
      for (int i = 15; i >= 0; i--) begin
         if (KEY_CODES[i] == code) begin
            key = KEY_BITS'(i);
         end
      end
      return key;
   endfunction

endpackage

>>> sv/keypad_debounce_long_press_repeat.sv
// Keypad scanner for a 4x4 matrix: each item is one scan (active-low row/column code and
// the tick counter) and gives exactly one result item, with key_valid set when a key is
// reported. A key is confirmed by two equal scans, a short press is reported on release,
// and a hold beyond long_press_ticks then reports the key each time more than
// repeat_ticks have passed; tick differences wrap modulo 2^32. One item is taken every
// cycle while results are taken; an item goes into an input register, and the phase
// machine updates its state as the item moves on from there into the result register.
// A stalled result holds the item behind it in the input register. Register writes
// through the csr port take effect on the next item.
module keypad_debounce_long_press_repeat (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  kpd_pkg::req_item_type              req_item,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output kpd_pkg::rsp_item_type              rsp_item,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [kpd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [kpd_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import kpd_pkg::*;

   logic                     in_valid_ff;
   req_item_type             in_item_ff;
   logic                     out_valid_ff;
   rsp_item_type             out_item_ff;
   logic                     advance;

   logic [CSR_DATA_BITS-1:0] long_press_ff;
   logic [CSR_DATA_BITS-1:0] repeat_ff;

   phase_type                phase_ff, phase_in;
   logic [KEY_BITS-1:0]      held_ff, held_in;
   logic [TICK_BITS-1:0]     mark_ff, mark_in;

   logic [KEY_BITS-1:0]      key;
   logic                     key_absent;
   logic [TICK_BITS-1:0]     elapsed;
   logic                     long_due;
   logic                     repeat_due;
   rsp_item_type             result;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;
   assign csr_ready = 1'b1;

   assign key        = decode_scan(in_item_ff.scan_code);
   assign key_absent = (key == NO_KEY);
   assign elapsed    = in_item_ff.tick_now - mark_ff;
   assign long_due   = elapsed > TICK_BITS'(long_press_ff);
   assign repeat_due = elapsed > TICK_BITS'(repeat_ff);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PHASE_IDLE: begin
            if (!key_absent) phase_in = PHASE_TRIG;
         end
         PHASE_TRIG: begin
            phase_in = (held_ff == key) ? PHASE_PRESSED : PHASE_IDLE;
         end
         PHASE_PRESSED: begin
            if (key_absent) phase_in = PHASE_IDLE;
            else if (long_due) phase_in = PHASE_LONG;
         end
         PHASE_LONG: begin
            if (key_absent) phase_in = PHASE_IDLE;
         end
         default: phase_in = PHASE_IDLE;
      endcase
   end

   // held key, mark and report
   always_comb begin
      held_in          = held_ff;
      mark_in          = mark_ff;
      result.key_valid = 1'b0;
      result.key_index = '0;
      case (phase_ff)
         PHASE_IDLE: begin
            held_in = key;
         end
         PHASE_TRIG: begin
            if (held_ff == key) mark_in = in_item_ff.tick_now;
            else held_in = NO_KEY;
         end
         PHASE_PRESSED: begin
            if (key_absent) begin
               if (!held_ff[KEY_BITS-1]) begin
                  result.key_valid = 1'b1;
                  result.key_index = held_ff[3:0];
               end
            end else if (long_due) begin
               mark_in = in_item_ff.tick_now;
            end
         end
         PHASE_LONG: begin
            if (!key_absent && repeat_due) begin
               mark_in = in_item_ff.tick_now;
               if (!held_ff[KEY_BITS-1]) begin
                  result.key_valid = 1'b1;
                  result.key_index = held_ff[3:0];
               end
            end
         end
         default: begin
            held_in = NO_KEY;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         phase_ff      <= PHASE_IDLE;
         held_ff       <= NO_KEY;
         mark_ff       <= '0;
         long_press_ff <= LONG_PRESS_RESET;
         repeat_ff     <= REPEAT_RESET;
      end else begin
         if (req_ready) in_valid_ff <= req_valid;
         if (advance) begin
            out_valid_ff <= 1'b1;
            phase_ff     <= phase_in;
            held_ff      <= held_in;
            mark_ff      <= mark_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            if (csr_index == CSR_LONG_PRESS) long_press_ff <= csr_wdata;
            else if (csr_index == CSR_REPEAT) repeat_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_item_ff <= req_item;
      if (advance) out_item_ff <= result;
   end

endmodule
